FILE: sv/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg: shared types and tables for the decimal string to fixed-point parser
// Character classes, parser phases, powers of ten and register decode.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam int unsigned PosBits   = 16;
  localparam int unsigned WholeBits = 64;
  localparam int unsigned FracBits  = 37;
  localparam int unsigned CfgBits   = 4;
  localparam int unsigned StopBits  = 16;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrBits  = $clog2(QDepth);
  localparam int unsigned QCntBits  = $clog2(QDepth + 1);

  localparam logic [CfgBits-1:0] CfgReset  = 4'd6;
  localparam logic [CfgBits-1:0] MinDigits = 4'd1;
  localparam logic [CfgBits-1:0] MaxDigits = 4'd11;
  localparam logic [3:0]         RoundUp   = 4'd5;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChPoint = 8'h2E;  // '.'
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'

  typedef logic [FracBits-1:0]  frac_t;
  typedef logic [WholeBits-1:0] whole_t;
  typedef logic [PosBits-1:0]   pos_t;

  typedef enum logic [2:0] {
    PH_SIGN,
    PH_INT,
    PH_POINT,
    PH_FRAC,
    PH_SKIP,
    PH_ERR
  } phase_t;

  // One classified character
  typedef struct packed {
    logic       nul;
    logic       digit;
    logic       sign;
    logic       minus;
    logic       point;
    logic [3:0] dval;
  } item_t;

  function automatic item_t classify(input logic [7:0] ch);
    item_t it;
    it.nul   = (ch == ChNul);
    it.digit = (ch >= ChZero) && (ch <= ChNine);
    it.minus = (ch == ChMinus);
    it.sign  = (ch == ChMinus) || (ch == ChPlus);
    it.point = (ch == ChPoint);
    it.dval  = it.digit ? 4'(ch - ChZero) : 4'd0;
    return it;
  endfunction

  function automatic frac_t pow10(input logic [3:0] idx);
    frac_t p;
    case (idx)
      4'd0:    p = 37'd1;
      4'd1:    p = 37'd10;
      4'd2:    p = 37'd100;
      4'd3:    p = 37'd1000;
      4'd4:    p = 37'd10000;
      4'd5:    p = 37'd100000;
      4'd6:    p = 37'd1000000;
      4'd7:    p = 37'd10000000;
      4'd8:    p = 37'd100000000;
      4'd9:    p = 37'd1000000000;
      4'd10:   p = 37'd10000000000;
      4'd11:   p = 37'd100000000000;
      default: p = 37'd100000000000;
    endcase
    return p;
  endfunction

  // Out-of-range register values clamp to 1..11
  function automatic logic [CfgBits-1:0] eff_digits(input logic [CfgBits-1:0] cfg);
    logic [CfgBits-1:0] e;
    if (cfg < MinDigits) begin
      e = MinDigits;
    end else if (cfg > MaxDigits) begin
      e = MaxDigits;
    end else begin
      e = cfg;
    end
    return e;
  endfunction

endpackage

FILE: sv/dsfp_front.sv
// ----------------------------------------------------------------------------
// dsfp_front: input stage
// Classifies and registers one character per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module dsfp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  output logic            push_valid,
  input  logic            push_ready,
  output dsfp_pkg::item_t push_item
);

  logic            valid;
  dsfp_pkg::item_t item;

  assign in_ready   = !valid || push_ready;
  assign push_valid = valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (push_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= dsfp_pkg::classify(ch);
    end
  end

endmodule

FILE: sv/dsfp_queue.sv
// ----------------------------------------------------------------------------
// dsfp_queue: short FIFO of classified characters
// Decouples the input stage from the parser so each can stall on its own.
// ----------------------------------------------------------------------------
module dsfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dsfp_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dsfp_pkg::item_t pop_item
);

  dsfp_pkg::item_t                    slots [dsfp_pkg::QDepth];
  logic [dsfp_pkg::QPtrBits-1:0]      wr_ptr;
  logic [dsfp_pkg::QPtrBits-1:0]      rd_ptr;
  logic [dsfp_pkg::QCntBits-1:0]      count;
  logic                               push;
  logic                               pop;

  assign push_ready = (count != dsfp_pkg::QCntBits'(dsfp_pkg::QDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dsfp_pkg::QPtrBits'(dsfp_pkg::QDepth - 1)) ? '0
                : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dsfp_pkg::QPtrBits'(dsfp_pkg::QDepth - 1)) ? '0
                : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/dsfp_back.sv
// ----------------------------------------------------------------------------
// dsfp_back: parser core
// Runs the sign/int/point/frac/skip phases one character a cycle (a terminator
// waits on a free output slot), finalizes sign and borrow, registers the result.
// ----------------------------------------------------------------------------
module dsfp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dsfp_pkg::CfgBits-1:0]       cfg_wdata,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  dsfp_pkg::item_t                    pop_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dsfp_pkg::WholeBits-1:0] whole_part,
  output logic [dsfp_pkg::FracBits-1:0]      frac_part,
  output logic                               ok,
  output logic [dsfp_pkg::StopBits-1:0]      stop_position
);

  localparam dsfp_pkg::pos_t PosMax = '1;
  localparam dsfp_pkg::pos_t StopMax = dsfp_pkg::PosBits'({dsfp_pkg::StopBits{1'b1}});

  logic [dsfp_pkg::CfgBits-1:0] frac_digits;
  dsfp_pkg::phase_t             phase, phase_next;
  logic                         negative, negative_next;
  dsfp_pkg::whole_t             whole_accum, whole_accum_next;
  dsfp_pkg::frac_t              frac_accum, frac_accum_next;
  logic [3:0]                   frac_count, frac_count_next;
  logic                         error_flag, error_flag_next;
  dsfp_pkg::pos_t               position, position_next;

  logic [dsfp_pkg::CfgBits-1:0] eff;
  logic [3:0]                   frac_idx;
  dsfp_pkg::whole_t             fin_whole;
  dsfp_pkg::frac_t              fin_frac;
  dsfp_pkg::whole_t             mac_whole;
  dsfp_pkg::frac_t              frac_add;
  logic [dsfp_pkg::StopBits-1:0] stop_sat;
  logic                         pop;
  logic                         out_load;
  logic                         bad;

  assign eff       = dsfp_pkg::eff_digits(frac_digits);
  assign frac_idx  = eff - 4'd1 - frac_count;
  assign mac_whole = (whole_accum << 3) + (whole_accum << 1)
                   + dsfp_pkg::WholeBits'(pop_item.dval);
  assign frac_add  = frac_accum
                   + dsfp_pkg::frac_t'(pop_item.dval * dsfp_pkg::pow10(frac_idx));
  assign stop_sat  = (position > StopMax) ? '1 : dsfp_pkg::StopBits'(position);

  // A NUL may only leave when the output slot is free or draining
  assign pop_ready = !pop_item.nul || !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Negative with nonzero fraction: borrow one (-w - 1 == ~w), complement fraction
  always_comb begin
    if (negative && (frac_accum != '0)) begin
      fin_whole = ~whole_accum;
      fin_frac  = dsfp_pkg::pow10(eff) - frac_accum;
    end else if (negative) begin
      fin_whole = '0 - whole_accum;
      fin_frac  = frac_accum;
    end else begin
      fin_whole = whole_accum;
      fin_frac  = frac_accum;
    end
  end

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    whole_accum_next = whole_accum;
    frac_accum_next  = frac_accum;
    frac_count_next  = frac_count;
    error_flag_next  = error_flag;
    position_next    = position;
    out_load         = 1'b0;
    bad              = 1'b0;
    if (pop) begin
      if (pop_item.nul) begin
        out_load         = 1'b1;
        phase_next       = dsfp_pkg::PH_SIGN;
        negative_next    = 1'b0;
        whole_accum_next = '0;
        frac_accum_next  = '0;
        frac_count_next  = '0;
        error_flag_next  = 1'b0;
        position_next    = '0;
      end else if (phase != dsfp_pkg::PH_ERR) begin
        case (phase)
          dsfp_pkg::PH_SIGN: begin
            if (pop_item.sign) begin
              negative_next = pop_item.minus;
              phase_next    = dsfp_pkg::PH_INT;
            end else if (pop_item.digit) begin
              whole_accum_next = mac_whole;
              phase_next       = dsfp_pkg::PH_INT;
            end else if (pop_item.point) begin
              phase_next = dsfp_pkg::PH_POINT;
            end else begin
              bad = 1'b1;
            end
          end
          dsfp_pkg::PH_INT: begin
            if (pop_item.digit) begin
              whole_accum_next = mac_whole;
            end else if (pop_item.point) begin
              phase_next = dsfp_pkg::PH_POINT;
            end else begin
              bad = 1'b1;
            end
          end
          dsfp_pkg::PH_POINT: begin
            if (pop_item.digit) begin
              frac_accum_next = frac_add;
              frac_count_next = frac_count + 4'd1;
              phase_next      = dsfp_pkg::PH_FRAC;
            end else begin
              bad = 1'b1;
            end
          end
          dsfp_pkg::PH_FRAC: begin
            if (pop_item.digit) begin
              if (frac_count < eff) begin
                frac_accum_next = frac_add;
                frac_count_next = frac_count + 4'd1;
              end else begin
                // rounding digit
                if (pop_item.dval >= dsfp_pkg::RoundUp) begin
                  frac_accum_next = frac_accum + dsfp_pkg::frac_t'(1);
                end
                phase_next = dsfp_pkg::PH_SKIP;
              end
            end else begin
              bad = 1'b1;
            end
          end
          default: begin
            if (!pop_item.digit) begin
              bad = 1'b1;
            end
          end
        endcase
        if (bad) begin
          whole_accum_next = fin_whole;
          frac_accum_next  = fin_frac;
          negative_next    = 1'b0;
          error_flag_next  = 1'b1;
          phase_next       = dsfp_pkg::PH_ERR;
        end else if (position != PosMax) begin
          position_next = position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= dsfp_pkg::CfgReset;
      phase       <= dsfp_pkg::PH_SIGN;
      negative    <= 1'b0;
      whole_accum <= '0;
      frac_accum  <= '0;
      frac_count  <= '0;
      error_flag  <= 1'b0;
      position    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frac_digits <= cfg_wdata;
      end
      phase       <= phase_next;
      negative    <= negative_next;
      whole_accum <= whole_accum_next;
      frac_accum  <= frac_accum_next;
      frac_count  <= frac_count_next;
      error_flag  <= error_flag_next;
      position    <= position_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // In the error phase negative is clear, so the finalized values are the raw ones
  always_ff @(posedge clk) begin
    if (out_load) begin
      whole_part    <= fin_whole;
      frac_part     <= fin_frac;
      ok            <= !error_flag;
      stop_position <= stop_sat;
    end
  end

  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == dsfp_pkg::PH_ERR) == error_flag)
    else $error("error flag and error phase disagree");

  a_frac_count: assert property (@(posedge clk) disable iff (rst)
    frac_count <= dsfp_pkg::MaxDigits)
    else $error("fraction digit count out of range");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    pop && pop_item.nul |=> phase == dsfp_pkg::PH_SIGN && position == '0 && !error_flag)
    else $error("terminator did not restart the parser");

  a_err_frozen: assert property (@(posedge clk) disable iff (rst)
    phase == dsfp_pkg::PH_ERR && !(pop && pop_item.nul)
    |=> $stable(position) && $stable(whole_accum) && $stable(frac_accum))
    else $error("values moved after a bad character");

endmodule

FILE: sv/decimal_string_to_fixed_point_top.sv
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point_top: streaming decimal string parser
// Converts a signed decimal string to a whole part and a fixed-point fraction.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | ch
//  out     | out_valid / out_ready| whole_part, frac_part, ok, stop_position
//  cfg     | cfg_we (no wait)     | cfg_wdata (frac_digits)
//
// One character per cycle sustained while no terminator waits on out_ready;
// each whole-part digit takes one multiply-by-ten accumulate in the parser core.
// A terminator's result passes the input register, the queue and the output
// register. Reset needs no clearing pass; frac_digits resets to 6.
// out_ready low stalls only a terminator; other characters keep flowing and
// the two-entry queue absorbs short stalls before in_ready drops.
// ----------------------------------------------------------------------------
module decimal_string_to_fixed_point_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dsfp_pkg::CfgBits-1:0]          cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            ch,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dsfp_pkg::WholeBits-1:0] whole_part,
  output logic [dsfp_pkg::FracBits-1:0]         frac_part,
  output logic                                  ok,
  output logic [dsfp_pkg::StopBits-1:0]         stop_position
);

  logic            push_valid;
  logic            push_ready;
  dsfp_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  dsfp_pkg::item_t pop_item;

  dsfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dsfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dsfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .whole_part    (whole_part),
    .frac_part     (frac_part),
    .ok            (ok),
    .stop_position (stop_position)
  );

endmodule
